// ===== rtl/core/lsp_pkg.sv =====
// Shared types, codes and the color reorder function for the LED strip pixel buffer.
`default_nettype none

package lsp_pkg;

  typedef logic [2:0] slot_t;

  typedef struct packed {
    slot_t s0;
    slot_t s1;
    slot_t s2;
    slot_t s3;
  } slot_cfg_t;

  // read request handed to the output queue
  typedef struct packed {
    logic issue;
    logic last;
  } lsp_rd_req_t;

  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_FILL = 2'd1;
  localparam logic [1:0] OP_SHOW = 2'd2;

  localparam slot_t SLOT_NONE  = 3'd0;
  localparam slot_t SLOT_RED   = 3'd1;
  localparam slot_t SLOT_GREEN = 3'd2;
  localparam slot_t SLOT_BLUE  = 3'd3;
  localparam slot_t SLOT_WHITE = 3'd4;

  localparam logic [2:0] REG_SLOT0  = 3'd0;
  localparam logic [2:0] REG_SLOT1  = 3'd1;
  localparam logic [2:0] REG_SLOT2  = 3'd2;
  localparam logic [2:0] REG_SLOT3  = 3'd3;
  localparam logic [2:0] REG_LENGTH = 3'd4;

  localparam int CFG_W = 7;

  function automatic logic [7:0] channel_byte(slot_t sel, logic [31:0] rgbw);
    case (sel)
      SLOT_RED:   return rgbw[7:0];
      SLOT_GREEN: return rgbw[15:8];
      SLOT_BLUE:  return rgbw[23:16];
      SLOT_WHITE: return rgbw[31:24];
      default:    return 8'h00;
    endcase
  endfunction

  // wire order, left aligned; 24-bit word when slot 0 is unused
  function automatic logic [31:0] reorder(slot_cfg_t cfg, logic [31:0] rgbw);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    b0 = channel_byte(cfg.s0, rgbw);
    b1 = channel_byte(cfg.s1, rgbw);
    b2 = channel_byte(cfg.s2, rgbw);
    b3 = channel_byte(cfg.s3, rgbw);
    if (cfg.s0 == SLOT_NONE) begin
      return {b1, b2, b3, 8'h00};
    end
    return {b0, b1, b2, b3};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/led_strip_pixel_buffer.sv =====
// Top level of the LED strip pixel buffer: config registers, pixel store and sequencer.
`default_nettype none

// Frame store for an addressable LED strip. Each request carries an opcode:
// set writes one reordered pixel (ignored at or beyond the strip length),
// fill writes the same word over a range whose end is clamped to the strip
// length, and show streams every stored word of the strip with last_pixel on
// the final one. Colors arrive packed (red 7:0, green 15:8, blue 23:16,
// white 31:24) and are reordered with the slot selectors in force when the
// request is accepted; the store keeps the wire-ordered word. After reset
// the store is cleared word by word, during which no request is taken
// (config writes are). A set is written when it is accepted; a fill then
// writes its pixels in order from the FILL state; a show then reads its
// pixels from the SHOW state. The single store write port and single read
// port each move one word a cycle, the read port only while the output
// queue has room. Show words leave through an output register and a skid
// entry, so the next request is taken once a show's last read is issued.
module led_strip_pixel_buffer
  import lsp_pkg::*;
#(
  parameter int MAX_PIXELS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        opcode,
  input  wire logic [5:0]        pixel_index,
  input  wire logic [6:0]        fill_count,
  input  wire logic [31:0]       color,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            pixel_word,
  output logic                   last_pixel
);

  localparam int ADDR_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int LEN_CAP = (MAX_PIXELS < 127) ? MAX_PIXELS : 127;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_PIXELS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_FILL  = 2'd2;
  localparam logic [1:0] ST_SHOW  = 2'd3;

  // config registers
  slot_cfg_t   slots;
  logic [6:0]  strip_length;

  // sequencer
  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic [6:0]        cursor;
  logic [6:0]        cursor_next;
  logic [6:0]        end_idx;
  logic [6:0]        end_idx_next;
  logic [31:0]       fill_word;

  // store
  logic [31:0]       store [MAX_PIXELS];
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       wr_data;
  logic [31:0]       rd_data;

  logic        accept;
  logic [6:0]  len;
  logic [31:0] new_word;
  logic [7:0]  range_sum;
  logic [6:0]  fill_end;
  logic        room;
  logic        rd_is_last;
  lsp_rd_req_t rd_req;

  // ---------------------------------------------------------------------
  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      slots.s0     <= SLOT_NONE;
      slots.s1     <= SLOT_GREEN;
      slots.s2     <= SLOT_RED;
      slots.s3     <= SLOT_BLUE;
      strip_length <= 7'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SLOT0:  slots.s0     <= cfg_wr_data[2:0];
        REG_SLOT1:  slots.s1     <= cfg_wr_data[2:0];
        REG_SLOT2:  slots.s2     <= cfg_wr_data[2:0];
        REG_SLOT3:  slots.s3     <= cfg_wr_data[2:0];
        REG_LENGTH: strip_length <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // active length, saturated to the store depth
  assign len = (strip_length > 7'(LEN_CAP)) ? 7'(LEN_CAP) : strip_length;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign new_word = reorder(slots, color);

  // fill end = min(first + count, len)
  assign range_sum = {2'b00, pixel_index} + {1'b0, fill_count};
  assign fill_end  = (range_sum > {1'b0, len}) ? len : range_sum[6:0];

  assign rd_is_last    = (cursor + 7'd1 == end_idx);
  assign rd_req.issue  = (state == ST_SHOW) && room;
  assign rd_req.last   = rd_is_last;

  // ---------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_next   = state;
    cursor_next  = cursor;
    end_idx_next = end_idx;
    mem_we       = 1'b0;
    wr_addr      = ADDR_W'(pixel_index);
    wr_data      = new_word;
    case (state)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_addr;
        wr_data = 32'h0;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_SET: begin
              mem_we = ({1'b0, pixel_index} < len);
            end
            OP_FILL: begin
              cursor_next  = {1'b0, pixel_index};
              end_idx_next = fill_end;
              if ({1'b0, pixel_index} < fill_end) begin
                state_next = ST_FILL;
              end
            end
            OP_SHOW: begin
              cursor_next  = 7'd0;
              end_idx_next = len;
              if (len != 7'd0) begin
                state_next = ST_SHOW;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        mem_we      = 1'b1;
        wr_addr     = ADDR_W'(cursor);
        wr_data     = fill_word;
        cursor_next = cursor + 7'd1;
        if (rd_is_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_SHOW: begin
        if (rd_req.issue) begin
          cursor_next = cursor + 7'd1;
          if (rd_is_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cursor  <= cursor_next;
    end_idx <= end_idx_next;
    if (accept) begin
      fill_word <= new_word;
    end
  end

  // ---------------------------------------------------------------------
  // pixel store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_req.issue) begin
      rd_data <= store[ADDR_W'(cursor)];
    end
  end

  lsp_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .rd_req     (rd_req),
    .rd_data    (rd_data),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_word (pixel_word),
    .last_pixel (last_pixel)
  );

`ifndef SYNTHESIS
  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |-> (cursor < end_idx))
    else $error("fill write past range end");

  a_show_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_req.issue |-> (cursor < end_idx))
    else $error("show read past strip end");

  a_show_ends: assert property (@(posedge clk) disable iff (rst)
    (rd_req.issue && rd_is_last) |=> (state == ST_IDLE))
    else $error("show did not finish after last read");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!out_valid && !in_ready))
    else $error("activity during store clear");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lsp_out_queue.sv =====
// Output register with skid entry, fed by registered store reads.
`default_nettype none

module lsp_out_queue
  import lsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire lsp_rd_req_t rd_req,
  input  wire logic [31:0] rd_data,
  output logic             room,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      pixel_word,
  output logic             last_pixel
);

  logic        rd_pend;
  logic        rd_last;
  logic        o_valid;
  logic [31:0] o_word;
  logic        o_last;
  logic        s_valid;
  logic [31:0] s_word;
  logic        s_last;
  logic        pop;
  logic [1:0]  occ;

  assign pop = o_valid & out_ready;
  // slots held or in flight, after this cycle's pop
  assign occ  = {1'b0, o_valid} + {1'b0, s_valid} + {1'b0, rd_pend} - {1'b0, pop};
  assign room = (occ < 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else begin
      rd_pend <= rd_req.issue;
      rd_last <= rd_req.last;
      if (!o_valid || pop) begin
        if (s_valid) begin
          o_word  <= s_word;
          o_last  <= s_last;
          s_valid <= rd_pend;
          s_word  <= rd_data;
          s_last  <= rd_last;
        end else begin
          o_valid <= rd_pend;
          o_word  <= rd_data;
          o_last  <= rd_last;
        end
      end else if (rd_pend) begin
        s_valid <= 1'b1;
        s_word  <= rd_data;
        s_last  <= rd_last;
      end
    end
  end

  assign out_valid  = o_valid;
  assign pixel_word = o_word;
  assign last_pixel = o_last;

endmodule

`default_nettype wire
